>>> sv/gha_pkg.sv
// Shared types and codes for the generational handle allocator.
// No dependencies; used by the interfaces, gha_cfg and the allocator.
package gha_pkg;

  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;
  localparam int THR_W    = 11;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [OPCODE_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DESTROY = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CHECK   = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FRESH   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_QUEUE_FULL = 2'd2;

  localparam logic [PADDR_W-3:0] REG_REUSE_THRESHOLD = 1'd0;
  localparam logic [THR_W-1:0]   REUSE_THRESHOLD_RST = 11'd64;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QREAD,
    ST_GREAD
  } state_t;

  // What an accepted transaction will do, settled at accept time.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_REUSE,
    ACT_FRESH,
    ACT_FAIL,
    ACT_DESTROY,
    ACT_FULL,
    ACT_CHECK
  } act_t;

  typedef struct packed {
    logic [THR_W-1:0] reuse_threshold;
  } cfg_t;

endpackage

>>> sv/gha_if.sv
// Request and response channel interfaces (valid/ready plus payload).
// Depends on gha_pkg for field widths.
interface gha_req_if #(
  parameter int INDEX_WIDTH = 10,
  parameter int GEN_WIDTH   = 8
);
  logic                                valid;
  logic                                ready;
  logic [gha_pkg::OPCODE_W-1:0]        opcode;
  logic [GEN_WIDTH+INDEX_WIDTH-1:0]    handle;

  modport source (output valid, output opcode, output handle, input ready);
  modport sink   (input valid, input opcode, input handle, output ready);
endinterface

interface gha_rsp_if #(
  parameter int INDEX_WIDTH = 10,
  parameter int GEN_WIDTH   = 8
);
  logic                                valid;
  logic                                ready;
  logic [GEN_WIDTH+INDEX_WIDTH-1:0]    new_handle;
  logic                                alive;
  logic [gha_pkg::STATUS_W-1:0]        status;

  modport source (output valid, output new_handle, output alive, output status, input ready);
  modport sink   (input valid, input new_handle, input alive, input status, output ready);
endinterface

>>> sv/gha_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies; holds the generation table and the free queue.
module gha_ram #(
  parameter int AW = 10,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/gha_cfg.sv
// APB-style configuration register block (reuse threshold).
// Depends on gha_pkg for address/data widths and the cfg_t struct.
module gha_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gha_pkg::PADDR_W-1:0]   paddr,
  input  logic [gha_pkg::PDATA_W-1:0]   pwdata,
  output logic [gha_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output gha_pkg::cfg_t                 cfg
);
  import gha_pkg::*;

  logic reg_hit;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_REUSE_THRESHOLD);
  assign wr_en   = psel && penable && pwrite && pready && reg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reuse_threshold <= REUSE_THRESHOLD_RST;
    end else if (wr_en) begin
      cfg.reuse_threshold <= pwdata[THR_W-1:0];
    end
  end

  assign prdata = reg_hit ? PDATA_W'(cfg.reuse_threshold) : '0;

endmodule

>>> sv/generational_handle_allocator.sv
// Generational handle allocator: an accepted request goes to ST_GREAD, via ST_QREAD for the
// free-queue read when a create reuses a freed index, and its result is registered into
// the output register or skid slot. A new request is taken only in ST_IDLE with the skid slot
// free, after the read-modify-write through the generation memory. After reset a clearing
// pass zeroes the generation table with req.ready low; config writes still land.
// Depends on gha_pkg, gha_if, gha_ram and gha_cfg.
module generational_handle_allocator #(
  parameter int INDEX_WIDTH = 10,
  parameter int GEN_WIDTH   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  gha_req_if.sink                       req,
  gha_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gha_pkg::PADDR_W-1:0]   paddr,
  input  logic [gha_pkg::PDATA_W-1:0]   pwdata,
  output logic [gha_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import gha_pkg::*;

  localparam int HW = INDEX_WIDTH + GEN_WIDTH;
  localparam int CW = INDEX_WIDTH + 1;
  localparam int MW = (CW > THR_W) ? CW : THR_W;

  typedef struct packed {
    logic [HW-1:0]       new_handle;
    logic                alive;
    logic [STATUS_W-1:0] status;
  } res_t;

  state_t state, state_next;
  act_t   act, act_in;

  logic [INDEX_WIDTH-1:0] id;
  logic [GEN_WIDTH-1:0]   hgen;
  logic [INDEX_WIDTH-1:0] head, tail, clr_addr;
  logic [CW-1:0]          count, fresh;
  cfg_t                   cfg;

  logic                   gen_we, gen_re;
  logic [INDEX_WIDTH-1:0] gen_waddr, gen_raddr;
  logic [GEN_WIDTH-1:0]   gen_wdata, gen_rdata;
  logic                   q_we, q_re;
  logic [INDEX_WIDTH-1:0] q_rdata;

  logic accept, push, pop;
  logic head_valid, skid_valid;
  res_t head_res, skid_res, push_res;

  gha_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gha_ram #(.AW(INDEX_WIDTH), .DW(GEN_WIDTH)) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .re    (gen_re),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  gha_ram #(.AW(INDEX_WIDTH), .DW(INDEX_WIDTH)) u_free_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail),
    .wdata (id),
    .re    (q_re),
    .raddr (head),
    .rdata (q_rdata)
  );

  // Only one transaction in flight; the skid slot must be free so its result has room.
  assign req.ready = (state == ST_IDLE) && !skid_valid;
  assign accept    = req.valid && req.ready;
  assign pop       = rsp.valid && rsp.ready;

  always_comb begin
    act_in = ACT_NONE;
    case (req.opcode)
      OP_CREATE: begin
        if (count != '0 && MW'(count) > MW'(cfg.reuse_threshold)) begin
          act_in = ACT_REUSE;
        end else if (!fresh[INDEX_WIDTH]) begin
          act_in = ACT_FRESH;
        end else begin
          act_in = ACT_FAIL;
        end
      end
      OP_DESTROY: begin
        act_in = count[INDEX_WIDTH] ? ACT_FULL : ACT_DESTROY;
      end
      OP_CHECK: begin
        act_in = ACT_CHECK;
      end
      default: begin
        act_in = ACT_NONE;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (&clr_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (act_in == ACT_REUSE) ? ST_QREAD : ST_GREAD;
        end
      end
      ST_QREAD: begin
        state_next = ST_GREAD;
      end
      ST_GREAD: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Memory controls
  always_comb begin
    gen_we    = 1'b0;
    gen_waddr = clr_addr;
    gen_wdata = '0;
    gen_re    = 1'b0;
    gen_raddr = req.handle[INDEX_WIDTH-1:0];
    q_we      = 1'b0;
    q_re      = 1'b0;
    push      = 1'b0;
    case (state)
      ST_CLEAR: begin
        gen_we = 1'b1;
      end
      ST_IDLE: begin
        q_re   = accept;
        gen_re = accept && (act_in != ACT_REUSE);
        if (act_in == ACT_FRESH) begin
          gen_raddr = fresh[INDEX_WIDTH-1:0];
        end
      end
      ST_QREAD: begin
        gen_re    = 1'b1;
        gen_raddr = q_rdata;
      end
      ST_GREAD: begin
        push = 1'b1;
        if (act == ACT_DESTROY) begin
          gen_we    = 1'b1;
          gen_waddr = id;
          gen_wdata = gen_rdata + 1'b1;
          q_we      = 1'b1;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_comb begin
    push_res = '0;
    case (act)
      ACT_REUSE, ACT_FRESH: push_res.new_handle = {gen_rdata, id};
      ACT_CHECK:            push_res.alive      = (gen_rdata == hgen);
      ACT_FAIL:             push_res.status     = STAT_NO_FRESH;
      ACT_FULL:             push_res.status     = STAT_QUEUE_FULL;
      default:              push_res.status     = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      act      <= ACT_NONE;
      clr_addr <= '0;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      fresh    <= CW'(1);
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept) begin
        act <= act_in;
      end
      if (state == ST_GREAD) begin
        case (act)
          ACT_REUSE: begin
            head  <= head + 1'b1;
            count <= count - 1'b1;
          end
          ACT_FRESH: begin
            fresh <= fresh + 1'b1;
          end
          ACT_DESTROY: begin
            tail  <= tail + 1'b1;
            count <= count + 1'b1;
          end
          default: begin
            count <= count;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hgen <= req.handle[HW-1:INDEX_WIDTH];
      id   <= (act_in == ACT_FRESH) ? fresh[INDEX_WIDTH-1:0] : req.handle[INDEX_WIDTH-1:0];
    end else if (state == ST_QREAD) begin
      id <= q_rdata;
    end
  end

  // Output register with a skid slot behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!head_valid || pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        head_res   <= skid_res;
        skid_valid <= push;
        if (push) begin
          skid_res <= push_res;
        end
      end else begin
        head_valid <= push;
        if (push) begin
          head_res <= push_res;
        end
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_res   <= push_res;
    end
  end

  assign rsp.valid      = head_valid;
  assign rsp.new_handle = head_res.new_handle;
  assign rsp.alive      = head_res.alive;
  assign rsp.status     = head_res.status;

endmodule
